>>> rtl/dpb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpb_pkg: shared types and constants
// Field widths, derived datapath widths, register indexes and reset values
// for the depth pixel back-projection unit.
// ----------------------------------------------------------------------------
package dpb_pkg;

    // pixel coordinate width (8..16)
    localparam int COORD_W   = 12;

    localparam int CODE_W    = 16;
    localparam int COLOR_W   = 8;
    localparam int SCALE_W   = 24;
    localparam int CENTER_W  = 20;
    localparam int INV_W     = 24;
    localparam int Z_W       = 24;
    localparam int POINT_W   = 28;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;

    // raw depth product and its Q.20 truncation
    localparam int ZPROD_W   = CODE_W + SCALE_W;
    localparam int ZFULL_W   = ZPROD_W - 4;

    // Q.8 pixel offset magnitude and the projection chain
    localparam int OFS_W     = (COORD_W + 8 > CENTER_W) ? COORD_W + 8 : CENTER_W;
    localparam int PROD_W    = OFS_W + INV_W;
    localparam int SPLIT_W   = 16;
    localparam int HI_W      = PROD_W - SPLIT_W;
    localparam int HIZ_W     = HI_W + Z_W;
    localparam int LOZ_W     = SPLIT_W + Z_W;
    localparam int SUM_W     = HIZ_W + 1;
    localparam int R_W       = SUM_W - SPLIT_W;

    // saturation limits (magnitudes)
    localparam logic [R_W-1:0] SAT_POS = R_W'((64'd1 << (POINT_W - 1)) - 64'd1);
    localparam logic [R_W-1:0] SAT_NEG = R_W'(64'd1 << (POINT_W - 1));

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEPTH_SCALE = 3'd0,
        REG_CENTER_X    = 3'd1,
        REG_CENTER_Y    = 3'd2,
        REG_INV_FOCAL_X = 3'd3,
        REG_INV_FOCAL_Y = 3'd4,
        REG_MAX_DEPTH   = 3'd5,
        REG_DROP_BLACK  = 3'd6
    } cfg_reg_t;

    localparam logic [SCALE_W-1:0]  RST_DEPTH_SCALE = 24'd4194;
    localparam logic [CENTER_W-1:0] RST_CENTER_X    = 20'd84193;
    localparam logic [CENTER_W-1:0] RST_CENTER_Y    = 20'd62107;
    localparam logic [INV_W-1:0]    RST_INV_FOCAL_X = 24'd27894;
    localparam logic [INV_W-1:0]    RST_INV_FOCAL_Y = 24'd27906;
    localparam logic [Z_W-1:0]      RST_MAX_DEPTH   = 24'd2097152;

    typedef struct packed {
        logic [SCALE_W-1:0]  depth_scale;
        logic [CENTER_W-1:0] center_x;
        logic [CENTER_W-1:0] center_y;
        logic [INV_W-1:0]    inv_focal_x;
        logic [INV_W-1:0]    inv_focal_y;
        logic [Z_W-1:0]      max_depth;
        logic                drop_black;
    } cfg_t;

    // per-stage advance strobes
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } pipe_en_t;

endpackage
`default_nettype wire

>>> rtl/dpb_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpb_if: stream interfaces
// Pixel input stream and point output stream, valid/ready per beat.
// ----------------------------------------------------------------------------
interface dpb_pixel_if;
    logic                              valid;
    logic                              ready;
    logic [dpb_pkg::CODE_W-1:0]        depth_code;
    logic [dpb_pkg::COORD_W-1:0]       pixel_col;
    logic [dpb_pkg::COORD_W-1:0]       pixel_row;
    logic [dpb_pkg::COLOR_W-1:0]       blue;
    logic [dpb_pkg::COLOR_W-1:0]       green;
    logic [dpb_pkg::COLOR_W-1:0]       red;

    modport source (output valid, depth_code, pixel_col, pixel_row, blue, green, red,
                    input ready);
    modport sink   (input valid, depth_code, pixel_col, pixel_row, blue, green, red,
                    output ready);
endinterface

interface dpb_point_if;
    logic                              valid;
    logic                              ready;
    logic signed [dpb_pkg::POINT_W-1:0] point_x;
    logic signed [dpb_pkg::POINT_W-1:0] point_y;
    logic [dpb_pkg::Z_W-1:0]           point_z;
    logic [dpb_pkg::COLOR_W-1:0]       out_blue;
    logic [dpb_pkg::COLOR_W-1:0]       out_green;
    logic [dpb_pkg::COLOR_W-1:0]       out_red;

    modport source (output valid, point_x, point_y, point_z, out_blue, out_green, out_red,
                    input ready);
    modport sink   (input valid, point_x, point_y, point_z, out_blue, out_green, out_red,
                    output ready);
endinterface
`default_nettype wire

>>> rtl/depth_pixel_backprojection_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// depth_pixel_backprojection_unit: pinhole depth-to-point back-projection
// Turns depth pixels into colored 3D points in Q.20 metres.
// ----------------------------------------------------------------------------
// Takes one pixel beat per clock when not held by back-pressure and presents
// its point on the output after four register stages (the input beat lands
// in the first, the last one is the output register). Sustained rate is one
// pixel per clock without back-pressure; every multiplier is followed by a
// register, so the stage depth is one multiply. Pixels with zero depth, depth
// above max_depth, or (with drop_black set) an all-black color produce no
// output beat; the drop is decided in stage 2 and leaves a bubble.
// Back-pressure on the point stream freezes the stages in front of the first
// free slot only, so bubbles are squeezed out and the input keeps taking
// beats while a finished point waits. Registers are meant to be written only
// while the pipeline is empty.
// ----------------------------------------------------------------------------
module depth_pixel_backprojection_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [dpb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [dpb_pkg::CFG_W-1:0]       cfg_data,
    dpb_pixel_if.sink                            pixel,
    dpb_point_if.source                          point
);

    dpb_pkg::cfg_t     cfg;
    dpb_pkg::pipe_en_t en;

    // stage valid bits
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    // stage 1: full Q.20 depth, color, black flag
    logic [dpb_pkg::ZPROD_W-1:0] zprod;
    logic [dpb_pkg::ZFULL_W-1:0] zfull_reg;
    logic [dpb_pkg::COLOR_W-1:0] b1_reg, g1_reg, r1_reg;
    logic                        black1_reg;

    // stage 2: depth window and drop decision
    logic                        keep;
    logic [dpb_pkg::Z_W-1:0]     z2_reg;
    logic [dpb_pkg::COLOR_W-1:0] b2_reg, g2_reg, r2_reg;

    // stages 3 and 4: z and color ride along with the lanes
    logic [dpb_pkg::Z_W-1:0]     z3_reg, z4_reg;
    logic [dpb_pkg::COLOR_W-1:0] b3_reg, g3_reg, r3_reg;
    logic [dpb_pkg::COLOR_W-1:0] b4_reg, g4_reg, r4_reg;

    dpb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // A stage advances when it is empty or the stage after it advances.
    always_comb
    begin
        en.s4 = !v4_reg || point.ready;
        en.s3 = !v3_reg || en.s4;
        en.s2 = !v2_reg || en.s3;
        en.s1 = !v1_reg || en.s2;
    end

    assign pixel.ready = en.s1;

    // z = (code * scale) >> 4
    assign zprod = dpb_pkg::ZPROD_W'(pixel.depth_code) * dpb_pkg::ZPROD_W'(cfg.depth_scale);

    // kept if 0 < z <= max_depth and not a dropped black pixel
    assign keep = (zfull_reg != '0)
               && (zfull_reg <= dpb_pkg::ZFULL_W'(cfg.max_depth))
               && !(cfg.drop_black && black1_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en.s1)
                v1_reg <= pixel.valid;
            if (en.s2)
                v2_reg <= v1_reg && keep;
            if (en.s3)
                v3_reg <= v2_reg;
            if (en.s4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            zfull_reg  <= zprod[dpb_pkg::ZPROD_W-1:4];
            b1_reg     <= pixel.blue;
            g1_reg     <= pixel.green;
            r1_reg     <= pixel.red;
            black1_reg <= (pixel.blue == '0) && (pixel.green == '0) && (pixel.red == '0);
        end
        if (en.s2)
        begin
            z2_reg <= zfull_reg[dpb_pkg::Z_W-1:0];
            b2_reg <= b1_reg;
            g2_reg <= g1_reg;
            r2_reg <= r1_reg;
        end
        if (en.s3)
        begin
            z3_reg <= z2_reg;
            b3_reg <= b2_reg;
            g3_reg <= g2_reg;
            r3_reg <= r2_reg;
        end
        if (en.s4)
        begin
            z4_reg <= z3_reg;
            b4_reg <= b3_reg;
            g4_reg <= g3_reg;
            r4_reg <= r3_reg;
        end
    end

    // x and y lanes; z enters them at stage 3 from the stage 2 register
    dpb_lane u_lane_x (
        .clk       (clk),
        .en        (en),
        .coord     (pixel.pixel_col),
        .center    (cfg.center_x),
        .inv_focal (cfg.inv_focal_x),
        .z         (z2_reg),
        .point     (point.point_x)
    );

    dpb_lane u_lane_y (
        .clk       (clk),
        .en        (en),
        .coord     (pixel.pixel_row),
        .center    (cfg.center_y),
        .inv_focal (cfg.inv_focal_y),
        .z         (z2_reg),
        .point     (point.point_y)
    );

    assign point.valid     = v4_reg;
    assign point.point_z   = z4_reg;
    assign point.out_blue  = b4_reg;
    assign point.out_green = g4_reg;
    assign point.out_red   = r4_reg;

endmodule
`default_nettype wire

>>> rtl/dpb_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpb_cfg: configuration registers
// Write-only register file; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module dpb_cfg (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [dpb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [dpb_pkg::CFG_W-1:0]       cfg_data,
    output dpb_pkg::cfg_t                        cfg
);

    dpb_pkg::cfg_t cfg_reg;
    dpb_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (dpb_pkg::cfg_reg_t'(cfg_index))
                dpb_pkg::REG_DEPTH_SCALE: cfg_next.depth_scale = cfg_data[dpb_pkg::SCALE_W-1:0];
                dpb_pkg::REG_CENTER_X:    cfg_next.center_x    = cfg_data[dpb_pkg::CENTER_W-1:0];
                dpb_pkg::REG_CENTER_Y:    cfg_next.center_y    = cfg_data[dpb_pkg::CENTER_W-1:0];
                dpb_pkg::REG_INV_FOCAL_X: cfg_next.inv_focal_x = cfg_data[dpb_pkg::INV_W-1:0];
                dpb_pkg::REG_INV_FOCAL_Y: cfg_next.inv_focal_y = cfg_data[dpb_pkg::INV_W-1:0];
                dpb_pkg::REG_MAX_DEPTH:   cfg_next.max_depth   = cfg_data[dpb_pkg::Z_W-1:0];
                dpb_pkg::REG_DROP_BLACK:  cfg_next.drop_black  = cfg_data[0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.depth_scale <= dpb_pkg::RST_DEPTH_SCALE;
            cfg_reg.center_x    <= dpb_pkg::RST_CENTER_X;
            cfg_reg.center_y    <= dpb_pkg::RST_CENTER_Y;
            cfg_reg.inv_focal_x <= dpb_pkg::RST_INV_FOCAL_X;
            cfg_reg.inv_focal_y <= dpb_pkg::RST_INV_FOCAL_Y;
            cfg_reg.max_depth   <= dpb_pkg::RST_MAX_DEPTH;
            cfg_reg.drop_black  <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

>>> rtl/dpb_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpb_lane: one coordinate projection lane
// Four stages: Q.8 offset, offset * 1/f, split product by z, sum/saturate.
// ----------------------------------------------------------------------------
module dpb_lane (
    input  wire logic                               clk,
    input  wire dpb_pkg::pipe_en_t                  en,
    input  wire logic [dpb_pkg::COORD_W-1:0]        coord,
    input  wire logic [dpb_pkg::CENTER_W-1:0]       center,
    input  wire logic [dpb_pkg::INV_W-1:0]          inv_focal,
    input  wire logic [dpb_pkg::Z_W-1:0]            z,      // aligned with stage 2
    output logic signed [dpb_pkg::POINT_W-1:0]      point
);

    // stage 1: offset magnitude and sign
    logic [dpb_pkg::OFS_W-1:0]  c_q8;
    logic [dpb_pkg::OFS_W-1:0]  ctr;
    logic                       neg_next;
    logic [dpb_pkg::OFS_W-1:0]  mag_next;
    logic [dpb_pkg::OFS_W-1:0]  mag_reg;
    logic                       neg1_reg;

    // stage 2: times reciprocal focal
    logic [dpb_pkg::PROD_W-1:0] a_reg;
    logic                       neg2_reg;

    // stage 3: split product by z
    logic [dpb_pkg::HIZ_W-1:0]  hiz_reg;
    logic [dpb_pkg::LOZ_W-1:0]  loz_reg;
    logic                       neg3_reg;

    // stage 4: recombine, saturate
    logic [dpb_pkg::SUM_W-1:0]   sum;
    logic [dpb_pkg::R_W-1:0]     r;
    logic [dpb_pkg::POINT_W-1:0] point_next;
    logic [dpb_pkg::POINT_W-1:0] point_reg;

    always_comb
    begin
        c_q8     = dpb_pkg::OFS_W'({coord, 8'd0});
        ctr      = dpb_pkg::OFS_W'(center);
        neg_next = c_q8 < ctr;
        mag_next = neg_next ? ctr - c_q8 : c_q8 - ctr;
    end

    always_comb
    begin
        sum = dpb_pkg::SUM_W'(hiz_reg)
            + dpb_pkg::SUM_W'(loz_reg[dpb_pkg::LOZ_W-1:dpb_pkg::SPLIT_W]);
        r   = sum[dpb_pkg::SUM_W-1:dpb_pkg::SPLIT_W];
        if (neg3_reg)
        begin
            if (r > dpb_pkg::SAT_NEG)
                point_next = dpb_pkg::POINT_W'(dpb_pkg::SAT_NEG);
            else
                point_next = ~r[dpb_pkg::POINT_W-1:0] + dpb_pkg::POINT_W'(1);
        end
        else
        begin
            if (r > dpb_pkg::SAT_POS)
                point_next = dpb_pkg::POINT_W'(dpb_pkg::SAT_POS);
            else
                point_next = r[dpb_pkg::POINT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            mag_reg  <= mag_next;
            neg1_reg <= neg_next;
        end
        if (en.s2)
        begin
            a_reg    <= dpb_pkg::PROD_W'(mag_reg) * dpb_pkg::PROD_W'(inv_focal);
            neg2_reg <= neg1_reg;
        end
        if (en.s3)
        begin
            hiz_reg  <= dpb_pkg::HIZ_W'(a_reg[dpb_pkg::PROD_W-1:dpb_pkg::SPLIT_W])
                      * dpb_pkg::HIZ_W'(z);
            loz_reg  <= dpb_pkg::LOZ_W'(a_reg[dpb_pkg::SPLIT_W-1:0]) * dpb_pkg::LOZ_W'(z);
            neg3_reg <= neg2_reg;
        end
        if (en.s4)
        begin
            point_reg <= point_next;
        end
    end

    assign point = $signed(point_reg);

endmodule
`default_nettype wire

>>> tb/tb_depth_pixel_backprojection_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_depth_pixel_backprojection_unit: self-checking bench for the back-projector
// Drives pixel beats, predicts each point from a shadow copy of the registers,
// and checks every point beat against the oldest prediction. Directed cases
// cover the depth window, black pixels, saturation and register masking.
// Random traffic follows under three flow-control mixes.
// ----------------------------------------------------------------------------
module tb_depth_pixel_backprojection_unit;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 7;
    // pipeline is four stages deep; settle wait after the last booked point
    localparam int SETTLE_CYCLES = 8;
    // cycles without any accepted beat before the run is called hung
    localparam int STALL_LIMIT  = 5000;
    localparam int RANDOM_SETS  = 6;
    localparam int PIXELS_PER_SET = 113;
    localparam int REPORT_LIMIT = 10;

    // no register lives at this index; writes to it must be ignored
    localparam logic [dpb_pkg::CFG_IDX_W-1:0] REG_NONE = 3'd7;

    localparam longint unsigned POS_LIMIT = (64'd1 << (dpb_pkg::POINT_W - 1)) - 64'd1;
    localparam longint unsigned NEG_LIMIT = 64'd1 << (dpb_pkg::POINT_W - 1);

    typedef struct packed {
        logic signed [dpb_pkg::POINT_W-1:0] x;
        logic signed [dpb_pkg::POINT_W-1:0] y;
        logic [dpb_pkg::Z_W-1:0]            z;
        logic [dpb_pkg::COLOR_W-1:0]        blue;
        logic [dpb_pkg::COLOR_W-1:0]        green;
        logic [dpb_pkg::COLOR_W-1:0]        red;
    } point_beat_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [dpb_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [dpb_pkg::CFG_W-1:0]      cfg_data;

    dpb_pixel_if pixel_bus ();
    dpb_point_if point_bus ();

    depth_pixel_backprojection_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pixel_bus),
        .point     (point_bus)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // shadow of the register file, kept in step with every write
    dpb_pkg::cfg_t active_cfg;
    point_beat_t   pending_points[$];

    int sender_gap_pct  = 0;
    int sink_stall_pct  = 0;
    int pixels_sent     = 0;
    int pixels_dropped  = 0;
    int points_checked  = 0;
    int bad_beats       = 0;
    int settings_used   = 0;
    int quiet_cycles    = 0;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // One axis: signed Q.8 offset from the principal point, scaled by the
    // reciprocal focal length and the depth, truncated toward zero, then
    // clamped to the signed point width.
    function automatic logic signed [dpb_pkg::POINT_W-1:0] project_axis(
        input logic [dpb_pkg::COORD_W-1:0]  coord,
        input logic [dpb_pkg::CENTER_W-1:0] center,
        input logic [dpb_pkg::INV_W-1:0]    inv,
        input logic [dpb_pkg::ZFULL_W-1:0]  depth
    );
        logic [20:0] pix_q8;
        logic [20:0] ofs;
        logic        below;
        logic [95:0] prod;
        logic [95:0] mag;
        pix_q8 = 21'({coord, 8'h00});
        below  = pix_q8 < 21'(center);
        ofs    = below ? 21'(center) - pix_q8 : pix_q8 - 21'(center);
        prod   = 96'(ofs) * 96'(inv) * 96'(depth);
        mag    = prod >> 32;
        if (below)
            return (mag > NEG_LIMIT) ? dpb_pkg::POINT_W'(NEG_LIMIT)
                                     : dpb_pkg::POINT_W'(96'd0 - mag);
        return (mag > POS_LIMIT) ? dpb_pkg::POINT_W'(POS_LIMIT) : dpb_pkg::POINT_W'(mag);
    endfunction

    // Returns 1 and fills pt when the pixel survives the depth and color gates.
    function automatic bit backproject_pixel(
        input  logic [dpb_pkg::CODE_W-1:0]  code,
        input  logic [dpb_pkg::COORD_W-1:0] col,
        input  logic [dpb_pkg::COORD_W-1:0] row,
        input  logic [dpb_pkg::COLOR_W-1:0] blue,
        input  logic [dpb_pkg::COLOR_W-1:0] green,
        input  logic [dpb_pkg::COLOR_W-1:0] red,
        output point_beat_t                 pt
    );
        logic [dpb_pkg::ZPROD_W-1:0] zprod;
        logic [dpb_pkg::ZFULL_W-1:0] depth;
        pt    = '0;
        zprod = dpb_pkg::ZPROD_W'(code) * dpb_pkg::ZPROD_W'(active_cfg.depth_scale);
        depth = zprod[dpb_pkg::ZPROD_W-1:4];
        if (depth == '0 || depth > dpb_pkg::ZFULL_W'(active_cfg.max_depth))
            return 1'b0;
        if (active_cfg.drop_black && blue == '0 && green == '0 && red == '0)
            return 1'b0;
        pt.x     = project_axis(col, active_cfg.center_x, active_cfg.inv_focal_x, depth);
        pt.y     = project_axis(row, active_cfg.center_y, active_cfg.inv_focal_y, depth);
        pt.z     = depth[dpb_pkg::Z_W-1:0];
        pt.blue  = blue;
        pt.green = green;
        pt.red   = red;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Register write: one cycle of cfg_we. The shadow applies the same width
    // mask the hardware does; unknown indexes leave it untouched.
    task automatic write_reg(input logic [dpb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dpb_pkg::CFG_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            dpb_pkg::REG_DEPTH_SCALE: active_cfg.depth_scale = value[dpb_pkg::SCALE_W-1:0];
            dpb_pkg::REG_CENTER_X:    active_cfg.center_x    = value[dpb_pkg::CENTER_W-1:0];
            dpb_pkg::REG_CENTER_Y:    active_cfg.center_y    = value[dpb_pkg::CENTER_W-1:0];
            dpb_pkg::REG_INV_FOCAL_X: active_cfg.inv_focal_x = value[dpb_pkg::INV_W-1:0];
            dpb_pkg::REG_INV_FOCAL_Y: active_cfg.inv_focal_y = value[dpb_pkg::INV_W-1:0];
            dpb_pkg::REG_MAX_DEPTH:   active_cfg.max_depth   = value[dpb_pkg::Z_W-1:0];
            dpb_pkg::REG_DROP_BLACK:  active_cfg.drop_black  = value[0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Sends one pixel beat and books its point, if any, once the beat is taken.
    // valid stays high on return so back-to-back beats need no second drive.
    task automatic send_pixel(
        input logic [dpb_pkg::CODE_W-1:0]  code,
        input logic [dpb_pkg::COORD_W-1:0] col,
        input logic [dpb_pkg::COORD_W-1:0] row,
        input logic [dpb_pkg::COLOR_W-1:0] blue,
        input logic [dpb_pkg::COLOR_W-1:0] green,
        input logic [dpb_pkg::COLOR_W-1:0] red
    );
        point_beat_t pt;
        while ($urandom_range(99) < sender_gap_pct) begin
            pixel_bus.valid <= 1'b0;
            @(posedge clk);
        end
        pixel_bus.valid      <= 1'b1;
        pixel_bus.depth_code <= code;
        pixel_bus.pixel_col  <= col;
        pixel_bus.pixel_row  <= row;
        pixel_bus.blue       <= blue;
        pixel_bus.green      <= green;
        pixel_bus.red        <= red;
        @(posedge clk);
        while (!pixel_bus.ready)
            @(posedge clk);
        pixels_sent++;
        if (backproject_pixel(code, col, row, blue, green, red, pt))
            pending_points.insert(pending_points.size(), pt);
        else
            pixels_dropped++;
    endtask

    // Lower valid, wait out every booked point, then let dropped pixels that
    // are still in the stages drain before anything touches the registers.
    task automatic settle_pipeline();
        pixel_bus.valid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Random pixel: mostly a depth code inside the accepted window, with some
    // zero, just-too-deep and unconstrained codes, and a few black pixels.
    task automatic send_random_pixel();
        longint unsigned scale;
        longint unsigned code_lo;
        longint unsigned code_hi;
        int              pick;
        logic [dpb_pkg::CODE_W-1:0]  code;
        logic [dpb_pkg::COLOR_W-1:0] blue;
        logic [dpb_pkg::COLOR_W-1:0] green;
        logic [dpb_pkg::COLOR_W-1:0] red;
        scale   = active_cfg.depth_scale;
        code_lo = 1;
        code_hi = 0;
        if (scale != 0) begin
            code_lo = (16 + scale - 1) / scale;
            code_hi = ((longint'(active_cfg.max_depth) + 1) * 16 - 1) / scale;
            if (code_hi > 65535)
                code_hi = 65535;
        end
        pick = $urandom_range(99);
        code = dpb_pkg::CODE_W'($urandom());
        if (pick < 4)
            code = '0;
        else if (pick < 8 && scale != 0 && code_hi < 65535)
            code = dpb_pkg::CODE_W'(code_hi + 1);
        else if (pick >= 16 && scale != 0 && code_lo <= code_hi)
            code = dpb_pkg::CODE_W'($urandom_range(32'(code_hi), 32'(code_lo)));
        blue  = dpb_pkg::COLOR_W'($urandom());
        green = dpb_pkg::COLOR_W'($urandom());
        red   = dpb_pkg::COLOR_W'($urandom());
        if ($urandom_range(99) < 6) begin
            blue  = '0;
            green = '0;
            red   = '0;
        end
        send_pixel(code, dpb_pkg::COORD_W'($urandom()), dpb_pkg::COORD_W'($urandom()),
                   blue, green, red);
    endtask

    // One register setting per random set; kinds 2 and 4 are the extremes.
    task automatic load_setting(input int kind);
        case (kind)
            2: begin
                write_reg(dpb_pkg::REG_DEPTH_SCALE, 24'hFFFFFF);
                write_reg(dpb_pkg::REG_CENTER_X,    24'hFFFFFF);
                write_reg(dpb_pkg::REG_CENTER_Y,    24'hFFFFFF);
                write_reg(dpb_pkg::REG_INV_FOCAL_X, 24'hFFFFFF);
                write_reg(dpb_pkg::REG_INV_FOCAL_Y, 24'hFFFFFF);
                write_reg(dpb_pkg::REG_MAX_DEPTH,   24'hFFFFFF);
                write_reg(dpb_pkg::REG_DROP_BLACK,  24'd1);
            end
            4: begin
                write_reg(dpb_pkg::REG_DEPTH_SCALE, 24'd1);
                write_reg(dpb_pkg::REG_CENTER_X,    24'd0);
                write_reg(dpb_pkg::REG_CENTER_Y,    24'd0);
                write_reg(dpb_pkg::REG_INV_FOCAL_X, 24'd1);
                write_reg(dpb_pkg::REG_INV_FOCAL_Y, 24'd1);
                write_reg(dpb_pkg::REG_MAX_DEPTH,   24'hFFFFFF);
                write_reg(dpb_pkg::REG_DROP_BLACK,  24'd0);
            end
            1, 5: begin
                // raw 24-bit values: upper bits of the narrow registers get masked
                write_reg(dpb_pkg::REG_DEPTH_SCALE,
                          dpb_pkg::CFG_W'($urandom_range(24'hFFFFFF, 1)));
                write_reg(dpb_pkg::REG_CENTER_X,    dpb_pkg::CFG_W'($urandom()));
                write_reg(dpb_pkg::REG_CENTER_Y,    dpb_pkg::CFG_W'($urandom()));
                write_reg(dpb_pkg::REG_INV_FOCAL_X, dpb_pkg::CFG_W'($urandom()));
                write_reg(dpb_pkg::REG_INV_FOCAL_Y, dpb_pkg::CFG_W'($urandom()));
                write_reg(dpb_pkg::REG_MAX_DEPTH,   dpb_pkg::CFG_W'($urandom()));
                write_reg(dpb_pkg::REG_DROP_BLACK,  dpb_pkg::CFG_W'($urandom()));
            end
            default: begin
                // camera-like intrinsics with a random principal point
                write_reg(dpb_pkg::REG_DEPTH_SCALE,
                          dpb_pkg::CFG_W'($urandom_range(20000, 1000)));
                write_reg(dpb_pkg::REG_CENTER_X,
                          dpb_pkg::CFG_W'($urandom_range(20'hFFFFF, 0)));
                write_reg(dpb_pkg::REG_CENTER_Y,
                          dpb_pkg::CFG_W'($urandom_range(20'hFFFFF, 0)));
                write_reg(dpb_pkg::REG_INV_FOCAL_X,
                          dpb_pkg::CFG_W'($urandom_range(60000, 10000)));
                write_reg(dpb_pkg::REG_INV_FOCAL_Y,
                          dpb_pkg::CFG_W'($urandom_range(60000, 10000)));
                write_reg(dpb_pkg::REG_MAX_DEPTH,
                          dpb_pkg::CFG_W'($urandom_range(24'hFFFFFF, 24'h100000)));
                write_reg(dpb_pkg::REG_DROP_BLACK,
                          dpb_pkg::CFG_W'($urandom_range(1, 0)));
            end
        endcase
        settings_used++;
    endtask

    // ------------------------------------------------------------------------
    // Point stream: random back-pressure and the scoreboard
    // ------------------------------------------------------------------------

    always @(posedge clk)
        point_bus.ready <= ($urandom_range(99) >= sink_stall_pct);

    // Values read here are the ones present at the edge: the DUT and the
    // drivers only update them in the nonblocking region.
    always @(posedge clk) begin
        point_beat_t got;
        point_beat_t want;
        if (rst_n && point_bus.valid && point_bus.ready) begin
            got.x     = point_bus.point_x;
            got.y     = point_bus.point_y;
            got.z     = point_bus.point_z;
            got.blue  = point_bus.out_blue;
            got.green = point_bus.out_green;
            got.red   = point_bus.out_red;
            if (pending_points.size() == 0) begin
                bad_beats++;
                if (bad_beats <= REPORT_LIMIT)
                    $display("ERROR %0t: point beat with none pending: x=%0d y=%0d z=%0d",
                             $realtime, got.x, got.y, got.z);
            end
            else begin
                want = pending_points.pop_front();
                points_checked++;
                if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                    got.blue !== want.blue || got.green !== want.green ||
                    got.red !== want.red) begin
                    bad_beats++;
                    if (bad_beats <= REPORT_LIMIT) begin
                        $display("ERROR %0t: point mismatch", $realtime);
                        $display("  expected x=%0d y=%0d z=%0d bgr=%02h %02h %02h",
                                 want.x, want.y, want.z, want.blue, want.green, want.red);
                        $display("  actual   x=%0d y=%0d z=%0d bgr=%02h %02h %02h",
                                 got.x, got.y, got.z, got.blue, got.green, got.red);
                    end
                end
            end
        end
    end

    // Watchdog: any accepted beat on either side counts as progress.
    always @(posedge clk) begin
        if ((pixel_bus.valid && pixel_bus.ready) || (point_bus.valid && point_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("ERROR: no beat accepted for %0d cycles", STALL_LIMIT);
            $display("depth_pixel_backprojection_unit test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset intrinsics: in-window pixels at both image corners, a black pixel
    // that must pass, a zero code, a code far past max_depth and one just under it.
    task automatic test_reset_defaults();
        send_pixel(16'd1000,  12'd0,    12'd0,    8'hFF, 8'hFF, 8'hFF);
        send_pixel(16'd1000,  12'd4095, 12'd4095, 8'h00, 8'h00, 8'h00);
        send_pixel(16'd0,     12'd320,  12'd240,  8'h11, 8'h22, 8'h33);
        send_pixel(16'd65535, 12'd320,  12'd240,  8'h44, 8'h55, 8'h66);
        send_pixel(16'd8000,  12'd1234, 12'd567,  8'h5A, 8'hA5, 8'h0F);
        settle_pipeline();
    endtask

    // With scale 16 the depth equals the code: probe both edges of the window,
    // a product under one Q.20 unit, and a zero scale.
    task automatic test_depth_window();
        write_reg(dpb_pkg::REG_DEPTH_SCALE, 24'd16);
        write_reg(dpb_pkg::REG_MAX_DEPTH,   24'd1000);
        send_pixel(16'd1000, 12'd10, 12'd20, 8'h01, 8'h02, 8'h03);
        send_pixel(16'd1001, 12'd10, 12'd20, 8'h01, 8'h02, 8'h03);
        send_pixel(16'd1,    12'd10, 12'd20, 8'h01, 8'h02, 8'h03);
        settle_pipeline();
        write_reg(dpb_pkg::REG_DEPTH_SCALE, 24'd15);
        send_pixel(16'd1, 12'd10, 12'd20, 8'h01, 8'h02, 8'h03);
        settle_pipeline();
        write_reg(dpb_pkg::REG_DEPTH_SCALE, 24'd0);
        send_pixel(16'd65535, 12'd10, 12'd20, 8'h01, 8'h02, 8'h03);
        settle_pipeline();
    endtask

    // Black filter on: only the all-zero pixel goes; a single set bit in any
    // byte keeps it. Then the filter is cleared through the width mask.
    task automatic test_black_pixels();
        write_reg(dpb_pkg::REG_DEPTH_SCALE, 24'd16);
        write_reg(dpb_pkg::REG_MAX_DEPTH,   24'hFFFFFF);
        write_reg(dpb_pkg::REG_DROP_BLACK,  24'd1);
        send_pixel(16'd500, 12'd100, 12'd200, 8'h00, 8'h00, 8'h00);
        send_pixel(16'd500, 12'd100, 12'd200, 8'h01, 8'h00, 8'h00);
        send_pixel(16'd500, 12'd100, 12'd200, 8'h00, 8'h00, 8'h80);
        send_pixel(16'd500, 12'd100, 12'd200, 8'h00, 8'h01, 8'h00);
        settle_pipeline();
        write_reg(dpb_pkg::REG_DROP_BLACK, 24'hFFFFFE);
        send_pixel(16'd500, 12'd100, 12'd200, 8'h00, 8'h00, 8'h00);
        settle_pipeline();
    endtask

    // Largest depth and focal terms: positive and negative clamping, a pixel
    // on the principal point, and zero reciprocal focals.
    task automatic test_projection_extremes();
        write_reg(dpb_pkg::REG_DEPTH_SCALE, 24'hFFFFFF);
        write_reg(dpb_pkg::REG_MAX_DEPTH,   24'hFFFFFF);
        write_reg(dpb_pkg::REG_INV_FOCAL_X, 24'hFFFFFF);
        write_reg(dpb_pkg::REG_INV_FOCAL_Y, 24'hFFFFFF);
        write_reg(dpb_pkg::REG_CENTER_X,    24'd0);
        write_reg(dpb_pkg::REG_CENTER_Y,    24'hFFFFF);
        send_pixel(16'd16, 12'd4095, 12'd0,    8'hFF, 8'h00, 8'hFF);
        send_pixel(16'd16, 12'd0,    12'd4095, 8'h00, 8'hFF, 8'h00);
        settle_pipeline();
        write_reg(dpb_pkg::REG_INV_FOCAL_X, 24'd0);
        write_reg(dpb_pkg::REG_INV_FOCAL_Y, 24'd0);
        send_pixel(16'd16, 12'd4095, 12'd4095, 8'h12, 8'h34, 8'h56);
        settle_pipeline();
        write_reg(dpb_pkg::REG_DEPTH_SCALE, dpb_pkg::RST_DEPTH_SCALE);
        write_reg(dpb_pkg::REG_MAX_DEPTH,   dpb_pkg::RST_MAX_DEPTH);
        write_reg(dpb_pkg::REG_INV_FOCAL_X, dpb_pkg::RST_INV_FOCAL_X);
        write_reg(dpb_pkg::REG_INV_FOCAL_Y, dpb_pkg::RST_INV_FOCAL_Y);
        write_reg(dpb_pkg::REG_CENTER_X,    24'd25600);
        write_reg(dpb_pkg::REG_CENTER_Y,    24'(4095 * 256));
        send_pixel(16'd4000, 12'd100, 12'd4095, 8'h77, 8'h88, 8'h99);
        settle_pipeline();
    endtask

    // Bits above a register's width are ignored, as is a write to an index
    // with no register behind it.
    task automatic test_register_masking();
        write_reg(dpb_pkg::REG_CENTER_X, 24'hF00000 | 24'd51200);
        write_reg(dpb_pkg::REG_CENTER_Y, 24'hA12345);
        write_reg(REG_NONE,              24'h000001);
        send_pixel(16'd3000, 12'd200, 12'd300,  8'hC0, 8'hFF, 8'hEE);
        send_pixel(16'd3000, 12'd0,   12'd4095, 8'h01, 8'h80, 8'h7F);
        settle_pipeline();
    endtask

    // Random traffic: two register settings under each flow-control mix.
    task automatic test_random_traffic();
        for (int set_idx = 0; set_idx < RANDOM_SETS; set_idx++) begin
            case (set_idx / 2)
                0: begin sender_gap_pct = 18; sink_stall_pct = 68; end
                1: begin sender_gap_pct = 68; sink_stall_pct = 18; end
                default: begin sender_gap_pct = 0; sink_stall_pct = 0; end
            endcase
            load_setting(set_idx);
            for (int n = 0; n < PIXELS_PER_SET; n++)
                send_random_pixel();
            settle_pipeline();
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial begin
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= dpb_pkg::REG_DEPTH_SCALE;
        cfg_data             <= '0;
        pixel_bus.valid      <= 1'b0;
        pixel_bus.depth_code <= '0;
        pixel_bus.pixel_col  <= '0;
        pixel_bus.pixel_row  <= '0;
        pixel_bus.blue       <= '0;
        pixel_bus.green      <= '0;
        pixel_bus.red        <= '0;

        active_cfg.depth_scale = dpb_pkg::RST_DEPTH_SCALE;
        active_cfg.center_x    = dpb_pkg::RST_CENTER_X;
        active_cfg.center_y    = dpb_pkg::RST_CENTER_Y;
        active_cfg.inv_focal_x = dpb_pkg::RST_INV_FOCAL_X;
        active_cfg.inv_focal_y = dpb_pkg::RST_INV_FOCAL_Y;
        active_cfg.max_depth   = dpb_pkg::RST_MAX_DEPTH;
        active_cfg.drop_black  = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_depth_window();
        test_black_pixels();
        test_projection_extremes();
        test_register_masking();
        test_random_traffic();

        if (pending_points.size() != 0) begin
            bad_beats += pending_points.size();
            $display("ERROR: %0d points never arrived", pending_points.size());
        end

        $display("Summary: %0d pixel beats sent, %0d points checked, %0d pixels dropped",
                 pixels_sent, points_checked, pixels_dropped);
        $display("Summary: %0d random register settings under three flow-control mixes",
                 settings_used);
        if (bad_beats == 0)
            $display("depth_pixel_backprojection_unit test passed");
        else
            $display("depth_pixel_backprojection_unit test failed");
        $finish;
    end

endmodule
